// ===== hdl/joystick_drive_and_arm_preset_control_macros.svh =====
// Assertion helpers shared by the control block.
`ifndef JOYSTICK_DRIVE_AND_ARM_PRESET_CONTROL_MACROS_SVH
`define JOYSTICK_DRIVE_AND_ARM_PRESET_CONTROL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JDAP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jdap check failed");

// Next-cycle implication, checked out of reset.
`define JDAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jdap check failed");

`endif

// ===== hdl/jdap_pkg.sv =====
package jdap_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 9;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DEAD_ZONE  = 3'd0,
    CFG_MID_TARGET = 3'd1,
    CFG_DOWN_STOP  = 3'd2,
    CFG_UP_STOP    = 3'd3
  } cfg_addr_t;

  typedef struct packed {
    logic [6:0] dz_thresh;
    logic [8:0] mid_target;
    logic [8:0] down_stop;
    logic [8:0] up_stop;
  } cfg_t;

  // buttons whose rising edge matters
  typedef struct packed {
    logic sweep;
    logic clamp;
    logic raise;
    logic lower;
    logic mid;
  } edge_btn_t;

  localparam logic [6:0] DEAD_ZONE_RST  = 7'd8;
  localparam logic [8:0] MID_TARGET_RST = 9'd30;
  localparam logic [8:0] DOWN_STOP_RST  = 9'd15;
  localparam logic [8:0] UP_STOP_RST    = 9'd145;

  localparam logic signed [7:0] INTAKE_FULL = 8'sd127;

  localparam logic signed [8:0] ARM_FULL   = 9'sd127;
  localparam logic signed [8:0] ARM_PRESET = 9'sd129;
  localparam logic signed [8:0] ARM_MID    = 9'sd30;
  localparam logic signed [8:0] ARM_STOP   = 9'sd0;

  // angle limits, compared at 11 bits signed
  localparam logic signed [10:0] MID_DOWN_STOP = 11'sd32;
  localparam logic signed [10:0] MID_UP_STOP   = 11'sd23;
  localparam logic signed [10:0] WRAP_STOP     = 11'sd330;

endpackage

// ===== hdl/joystick_drive_and_arm_preset_control.sv =====
// An accepted beat passes the input register, then the result register, to out_valid.
// Throughput: one beat per cycle unless out_stall holds the output; the input register
// feeds arm and drive logic, which loads the output register as it updates state.
// Reset (rst_n low, synchronous): pipeline empty, arm speed, piston flags and
// button history cleared, registers back to their default values.
module joystick_drive_and_arm_preset_control (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [jdap_pkg::CfgAddrW-1:0]     cfg_addr,
  input  logic [jdap_pkg::CfgDataW-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [7:0]                 in_left_y,
  input  logic signed [7:0]                 in_right_x,
  input  logic                              in_btn_intake_rev,
  input  logic                              in_btn_intake_fwd,
  input  logic                              in_btn_arm_up,
  input  logic                              in_btn_arm_down,
  input  logic                              in_btn_arm_mid,
  input  logic                              in_btn_arm_lower,
  input  logic                              in_btn_arm_raise,
  input  logic                              in_btn_clamp,
  input  logic                              in_btn_sweeper,
  input  logic signed [9:0]                 in_arm_angle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [8:0]                 out_left_cmd,
  output logic signed [8:0]                 out_right_cmd,
  output logic signed [7:0]                 out_intake_cmd,
  output logic signed [8:0]                 out_arm_cmd,
  output logic                              out_arm_hold,
  output logic                              out_clamp_out,
  output logic                              out_sweeper_out
);

`include "joystick_drive_and_arm_preset_control_macros.svh"

  jdap_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dz_thresh  <= jdap_pkg::DEAD_ZONE_RST;
      cfg_r.mid_target <= jdap_pkg::MID_TARGET_RST;
      cfg_r.down_stop  <= jdap_pkg::DOWN_STOP_RST;
      cfg_r.up_stop    <= jdap_pkg::UP_STOP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        jdap_pkg::CFG_DEAD_ZONE:  cfg_r.dz_thresh  <= cfg_wdata[6:0];
        jdap_pkg::CFG_MID_TARGET: cfg_r.mid_target <= cfg_wdata;
        jdap_pkg::CFG_DOWN_STOP:  cfg_r.down_stop  <= cfg_wdata;
        jdap_pkg::CFG_UP_STOP:    cfg_r.up_stop    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  logic                v1_r;
  logic signed [7:0]   ly_r;
  logic signed [7:0]   rx_r;
  logic                rev_r;
  logic                fwd_r;
  logic                up_r;
  logic                down_r;
  jdap_pkg::edge_btn_t btn_r;
  logic signed [9:0]   ang_r;

  logic v2_r;
  logic adv2;
  logic xfer;
  logic in_acc;

  assign adv2     = !v2_r || !out_stall;
  assign xfer     = v1_r && adv2;
  assign in_stall = v1_r && !adv2;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (xfer) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ly_r        <= in_left_y;
      rx_r        <= in_right_x;
      rev_r       <= in_btn_intake_rev;
      fwd_r       <= in_btn_intake_fwd;
      up_r        <= in_btn_arm_up;
      down_r      <= in_btn_arm_down;
      btn_r.mid   <= in_btn_arm_mid;
      btn_r.lower <= in_btn_arm_lower;
      btn_r.raise <= in_btn_arm_raise;
      btn_r.clamp <= in_btn_clamp;
      btn_r.sweep <= in_btn_sweeper;
      ang_r       <= in_arm_angle;
    end
  end

  logic signed [8:0] left_c;
  logic signed [8:0] right_c;
  logic signed [7:0] intake_c;
  logic signed [8:0] arm_c;
  logic              clamp_c;
  logic              sweeper_c;

  jdap_drive u_drive (
    .left_y     (ly_r),
    .right_x    (rx_r),
    .intake_rev (rev_r),
    .intake_fwd (fwd_r),
    .dz_thresh  (cfg_r.dz_thresh),
    .left_cmd   (left_c),
    .right_cmd  (right_c),
    .intake_cmd (intake_c)
  );

  jdap_arm u_arm (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (xfer),
    .man_up      (up_r),
    .man_down    (down_r),
    .btn         (btn_r),
    .angle_deg   (ang_r),
    .cfg         (cfg_r),
    .arm_cmd     (arm_c),
    .clamp_nxt   (clamp_c),
    .sweeper_nxt (sweeper_c)
  );

  // result stage
  logic signed [8:0] left_r;
  logic signed [8:0] right_r;
  logic signed [7:0] intake_r;
  logic signed [8:0] arm_r;
  logic              hold_r;
  logic              clamp_r;
  logic              sweeper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (xfer) begin
      v2_r <= 1'b1;
    end else if (!out_stall) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      left_r    <= left_c;
      right_r   <= right_c;
      intake_r  <= intake_c;
      arm_r     <= arm_c;
      hold_r    <= (arm_c == jdap_pkg::ARM_STOP);
      clamp_r   <= clamp_c;
      sweeper_r <= sweeper_c;
    end
  end

  assign out_valid       = v2_r;
  assign out_left_cmd    = left_r;
  assign out_right_cmd   = right_r;
  assign out_intake_cmd  = intake_r;
  assign out_arm_cmd     = arm_r;
  assign out_arm_hold    = hold_r;
  assign out_clamp_out   = clamp_r;
  assign out_sweeper_out = sweeper_r;

  `JDAP_ASSERT_NOW(a_stall_only_when_full, in_stall, v1_r && v2_r && out_stall)
  `JDAP_ASSERT_NOW(a_intake_code, v2_r, intake_r == 8'sd0 || intake_r == jdap_pkg::INTAKE_FULL || intake_r == -jdap_pkg::INTAKE_FULL)
  `JDAP_ASSERT_NEXT(a_result_stable_stalled, v2_r && out_stall && !xfer, v2_r && $stable(arm_r) && $stable(clamp_r))
  `JDAP_ASSERT_NEXT(a_beat_lands, xfer, v2_r)

endmodule

// ===== hdl/jdap_drive.sv =====
module jdap_drive (
  input  logic signed [7:0] left_y,
  input  logic signed [7:0] right_x,
  input  logic              intake_rev,
  input  logic              intake_fwd,
  input  logic        [6:0] dz_thresh,
  output logic signed [8:0] left_cmd,
  output logic signed [8:0] right_cmd,
  output logic signed [7:0] intake_cmd
);

  logic signed [8:0] ly_ext;
  logic signed [8:0] rx_ext;
  logic        [8:0] ly_mag;
  logic        [8:0] rx_mag;
  logic signed [8:0] ly_dz;
  logic signed [8:0] rx_dz;
  logic        [8:0] dz_ext;

  assign ly_ext = 9'(left_y);
  assign rx_ext = 9'(right_x);
  assign dz_ext = {2'b00, dz_thresh};

  // magnitude at 9 bits so that -128 reads as 128
  assign ly_mag = ly_ext[8] ? 9'(-ly_ext) : 9'(ly_ext);
  assign rx_mag = rx_ext[8] ? 9'(-rx_ext) : 9'(rx_ext);

  assign ly_dz = (ly_mag < dz_ext) ? 9'sd0 : ly_ext;
  assign rx_dz = (rx_mag < dz_ext) ? 9'sd0 : rx_ext;

  assign left_cmd  = ly_dz + rx_dz;
  assign right_cmd = ly_dz - rx_dz;

  always_comb begin
    if (intake_rev) begin
      intake_cmd = -jdap_pkg::INTAKE_FULL;
    end else if (intake_fwd) begin
      intake_cmd = jdap_pkg::INTAKE_FULL;
    end else begin
      intake_cmd = 8'sd0;
    end
  end

endmodule

// ===== hdl/jdap_arm.sv =====
module jdap_arm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                man_up,
  input  logic                man_down,
  input  jdap_pkg::edge_btn_t btn,
  input  logic signed   [9:0] angle_deg,
  input  jdap_pkg::cfg_t      cfg,
  output logic signed   [8:0] arm_cmd,
  output logic                clamp_nxt,
  output logic                sweeper_nxt
);

  logic signed [8:0]   speed_r;
  logic                clamp_r;
  logic                sweeper_r;
  jdap_pkg::edge_btn_t prev_r;
  jdap_pkg::edge_btn_t rise;

  logic signed [10:0] ang;
  logic signed [10:0] tgt;
  logic signed [10:0] down_stop;
  logic signed [10:0] up_stop;
  logic signed [8:0]  speed_nxt;

  assign rise      = btn & ~prev_r;
  assign ang       = 11'(angle_deg);
  assign tgt       = $signed({2'b00, cfg.mid_target});
  assign down_stop = $signed({2'b00, cfg.down_stop});
  assign up_stop   = $signed({2'b00, cfg.up_stop});

  always_comb begin
    speed_nxt = speed_r;
    if (man_up) begin
      speed_nxt = jdap_pkg::ARM_FULL;
    end else if (man_down) begin
      speed_nxt = -jdap_pkg::ARM_FULL;
    end else if (rise.mid) begin
      // at the target the previous speed carries over
      if (ang > tgt) begin
        speed_nxt = -jdap_pkg::ARM_MID;
      end else if (ang < tgt) begin
        speed_nxt = jdap_pkg::ARM_MID;
      end
    end else if (speed_r == -jdap_pkg::ARM_MID) begin
      if (ang <= jdap_pkg::MID_DOWN_STOP) speed_nxt = jdap_pkg::ARM_STOP;
    end else if (speed_r == jdap_pkg::ARM_MID) begin
      if (ang >= jdap_pkg::MID_UP_STOP) speed_nxt = jdap_pkg::ARM_STOP;
    end else if (rise.lower) begin
      speed_nxt = -jdap_pkg::ARM_PRESET;
    end else if (speed_r == -jdap_pkg::ARM_PRESET) begin
      if (ang <= down_stop || ang >= jdap_pkg::WRAP_STOP) speed_nxt = jdap_pkg::ARM_STOP;
    end else if (rise.raise) begin
      speed_nxt = jdap_pkg::ARM_PRESET;
    end else if (speed_r == jdap_pkg::ARM_PRESET) begin
      if (ang >= up_stop) speed_nxt = jdap_pkg::ARM_STOP;
    end else begin
      speed_nxt = jdap_pkg::ARM_STOP;
    end
  end

  assign arm_cmd     = speed_nxt;
  assign clamp_nxt   = clamp_r ^ rise.clamp;
  assign sweeper_nxt = sweeper_r ^ rise.sweep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= jdap_pkg::ARM_STOP;
      clamp_r   <= 1'b0;
      sweeper_r <= 1'b0;
      prev_r    <= '0;
    end else if (fire) begin
      speed_r   <= speed_nxt;
      clamp_r   <= clamp_nxt;
      sweeper_r <= sweeper_nxt;
      prev_r    <= btn;
    end
  end

endmodule
